@@ rtl/jfws_pkg.sv @@
// ---------------------------------------------------------------------------
// jfws_pkg: shared types, constants and helpers of the joystick wheel mixer
// Frame byte codes, register map, reset values and the small arithmetic
// helpers used by the frame decoder and the speed mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package jfws_pkg;

  // Frame byte codes.
  localparam logic [7:0] BYTE_STX      = 8'h02;
  localparam logic [7:0] BYTE_ETX      = 8'h03;
  localparam logic [7:0] BYTE_MAX_DATA = 8'd127;

  // Digit decoding constants.
  localparam logic signed [14:0] ASCII_ZERO  = 15'sd48;
  localparam logic signed [14:0] AXIS_OFFSET = 15'sd200;
  localparam logic signed [14:0] AXIS_MAX    = 15'sd100;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 7;
  localparam int AXIS_W  = 8;
  localparam int SPEED_W = 12;
  localparam int GAIN_W  = 4;
  localparam int LIMIT_W = 11;
  localparam int WIDE_W  = 13;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd500;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_SPEED_GAIN  = 1'b0,
    REG_SPEED_LIMIT = 1'b1
  } reg_idx_t;

  // Position inside a frame: waiting for STX, six digit slots, terminator.
  typedef enum logic [2:0] {
    POS_IDLE = 3'd0,
    POS_D1   = 3'd1,
    POS_D2   = 3'd2,
    POS_D3   = 3'd3,
    POS_D4   = 3'd4,
    POS_D5   = 3'd5,
    POS_D6   = 3'd6,
    POS_TERM = 3'd7
  } frame_pos_t;

  // Configuration register contents.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  // Decoded axes passed from the decoder stage to the mixer.
  typedef struct packed {
    logic                     valid;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } axes_t;

  // Three ASCII digits to a value, offset removed.
  function automatic logic signed [14:0] decode_triple(
    input logic [DIGIT_W-1:0] a,
    input logic [DIGIT_W-1:0] b,
    input logic [DIGIT_W-1:0] c
  );
    logic signed [14:0] sa;
    logic signed [14:0] sb;
    logic signed [14:0] sc;
    sa = $signed({8'b0, a}) - ASCII_ZERO;
    sb = $signed({8'b0, b}) - ASCII_ZERO;
    sc = $signed({8'b0, c}) - ASCII_ZERO;
    return sa * 15'sd100 + sb * 15'sd10 + sc - AXIS_OFFSET;
  endfunction

  // Clamp to a range; the lower bound wins first.
  function automatic logic signed [WIDE_W-1:0] clamp_wide(
    input logic signed [WIDE_W-1:0] v,
    input logic signed [WIDE_W-1:0] lo,
    input logic signed [WIDE_W-1:0] hi
  );
    logic signed [WIDE_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jfws_if.sv @@
// ---------------------------------------------------------------------------
// jfws_if: valid/ready channels of the joystick wheel mixer
// One channel carries received bytes, the other the wheel speed pair.
// ---------------------------------------------------------------------------
`default_nettype none

interface jfws_byte_if import jfws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface jfws_speed_if import jfws_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

`default_nettype wire

@@ rtl/jfws_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// jfws_cfg_regs: configuration registers on an APB-style port
// Holds the speed gain and the speed limit; writes complete in the access
// phase and reads return the register value.
// ---------------------------------------------------------------------------
`default_nettype none

module jfws_cfg_regs import jfws_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain  <= GAIN_RESET;
      cfg.limit <= LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPEED_GAIN:  cfg.gain  <= pwdata[GAIN_W-1:0];
        REG_SPEED_LIMIT: cfg.limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data selection.
  always_comb begin
    case (reg_idx)
      REG_SPEED_GAIN:  prdata = {{(32-GAIN_W){1'b0}}, cfg.gain};
      REG_SPEED_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, cfg.limit};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/jfws_frame_decoder.sv @@
// ---------------------------------------------------------------------------
// jfws_frame_decoder: byte framing and axis decoding
// Tracks the frame position, stores the six digit bytes and, on a valid
// terminator, registers the decoded X and Y axes when both are in range.
// ---------------------------------------------------------------------------
`default_nettype none

module jfws_frame_decoder import jfws_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   in_ready,
  input  wire logic              take,
  output axes_t                  axes
);

  frame_pos_t         pos;
  frame_pos_t         pos_next;
  logic [DIGIT_W-1:0] digits [6];
  logic               accept;
  logic               high_byte;
  logic               button_end;
  logic               digit_slot;
  logic               digit_wr;
  logic [2:0]         wr_idx;
  logic               frame_end;
  logic signed [14:0] x_raw;
  logic signed [14:0] y_raw;
  logic               axes_ok;

  // The stage takes a new byte whenever its result register is free or moving.
  assign in_ready = !axes.valid || take;
  assign accept   = in_valid && in_ready;

  assign high_byte  = in_byte > BYTE_MAX_DATA;
  assign button_end = (in_byte == BYTE_ETX) && (pos == POS_D2);
  assign digit_slot = (pos != POS_IDLE) && (pos != POS_TERM);
  assign digit_wr   = accept && digit_slot && !high_byte && !button_end;
  assign wr_idx     = 3'(pos - POS_D1);
  assign frame_end  = accept && (pos == POS_TERM) && (in_byte == BYTE_ETX);

  // Frame position: next state.
  always_comb begin
    pos_next = pos;
    case (pos)
      POS_IDLE: begin
        if (in_byte == BYTE_STX) begin
          pos_next = POS_D1;
        end
      end
      POS_TERM: pos_next = POS_IDLE;
      default: begin
        if (high_byte || button_end) begin
          pos_next = POS_IDLE;
        end else begin
          pos_next = frame_pos_t'(pos + 3'd1);
        end
      end
    endcase
  end

  // Frame position register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Digit store, written one slot per accepted data byte.
  always_ff @(posedge clk) begin
    if (digit_wr) begin
      digits[wr_idx] <= in_byte[DIGIT_W-1:0];
    end
  end

  // Axis decode and range check from the stored digits.
  assign x_raw   = decode_triple(digits[0], digits[1], digits[2]);
  assign y_raw   = decode_triple(digits[3], digits[4], digits[5]);
  assign axes_ok = (x_raw >= -AXIS_MAX) && (x_raw <= AXIS_MAX) &&
                   (y_raw >= -AXIS_MAX) && (y_raw <= AXIS_MAX);

  // Decoded axes register.
  always_ff @(posedge clk) begin
    if (rst) begin
      axes.valid <= 1'b0;
    end else if (in_ready) begin
      axes.valid <= frame_end && axes_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      axes.x <= x_raw[AXIS_W-1:0];
      axes.y <= y_raw[AXIS_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // Reset returns the decoder to waiting for a start byte.
  assert property (@(posedge clk) rst |=> pos == POS_IDLE)
    else $error("frame position not idle after reset");

  // Any byte in the terminator slot closes the frame.
  assert property (@(posedge clk) disable iff (rst)
    accept && pos == POS_TERM |=> pos == POS_IDLE)
    else $error("terminator slot did not close the frame");

  // Only in-range axes reach the mixer.
  assert property (@(posedge clk) disable iff (rst)
    axes.valid |-> (axes.x >= -8'sd100 && axes.x <= 8'sd100 &&
                    axes.y >= -8'sd100 && axes.y <= 8'sd100))
    else $error("out-of-range axis passed to mixer");
`endif

endmodule

`default_nettype wire

@@ rtl/jfws_mixer.sv @@
// ---------------------------------------------------------------------------
// jfws_mixer: axis scaling, clamping and differential-drive mix
// Scales the decoded axes by the gain, clamps them to the limit, mixes them
// into left and right wheel speeds and holds the result for the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module jfws_mixer import jfws_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire axes_t       axes,
  input  wire cfg_t        cfg,
  output logic             take,
  jfws_speed_if.source     wheel
);

  logic signed [WIDE_W-1:0] gain_w;
  logic signed [WIDE_W-1:0] lim_pos;
  logic signed [WIDE_W-1:0] lim_neg;
  logic signed [WIDE_W-1:0] x_scaled;
  logic signed [WIDE_W-1:0] y_scaled;
  logic signed [WIDE_W-1:0] xc;
  logic signed [WIDE_W-1:0] yc;
  logic signed [WIDE_W-1:0] left_n;
  logic signed [WIDE_W-1:0] right_n;

  // The result register loads when empty or when its request is taken.
  assign take = !wheel.valid || wheel.ready;

  // Scale and clamp both axes; X is turned around.
  assign gain_w   = $signed({{(WIDE_W-GAIN_W){1'b0}}, cfg.gain});
  assign lim_pos  = $signed({{(WIDE_W-LIMIT_W){1'b0}}, cfg.limit});
  assign lim_neg  = -lim_pos;
  assign x_scaled = -(WIDE_W'(axes.x) * gain_w);
  assign y_scaled = WIDE_W'(axes.y) * gain_w;
  assign xc       = clamp_wide(x_scaled, lim_neg, lim_pos);
  assign yc       = clamp_wide(y_scaled, lim_neg, lim_pos);

  // Mix: the wheel on the side of the turn slows down, never below -limit.
  always_comb begin
    left_n  = xc;
    right_n = xc;
    if (yc < 0) begin
      left_n = clamp_wide(xc + yc, lim_neg, xc);
    end else if (yc > 0) begin
      right_n = clamp_wide(xc - yc, lim_neg, xc);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel.valid <= 1'b0;
    end else if (take) begin
      wheel.valid <= axes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wheel.left_speed  <= left_n[SPEED_W-1:0];
      wheel.right_speed <= right_n[SPEED_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // Neither wheel speed is above the scaled, clamped X axis.
  assert property (@(posedge clk) disable iff (rst)
    take && axes.valid |-> (left_n <= xc && right_n <= xc))
    else $error("mixed speed exceeds the steering axis");
`endif

endmodule

`default_nettype wire

@@ rtl/joystick_frame_to_wheel_speeds_unit.sv @@
// ---------------------------------------------------------------------------
// joystick_frame_to_wheel_speeds_unit: joystick frame to wheel speeds
// Usage:
//   rx carries received serial bytes, one request per byte. A frame is STX,
//   six ASCII digits (X then Y) and ETX. wheel carries one request with the
//   left and right wheel speeds for every complete, in-range frame; other
//   bytes and frames give no request.
//   Configuration: speed_gain at byte address 0, speed_limit at address 4,
//   written over the APB-style port while the block is idle.
//   Throughput: one byte per cycle while rx.ready is high. After a frame's
//   ETX is accepted, its speeds pass the decoder register, then the
//   result register.
//   When the receiver stalls, the pending speeds hold and bytes keep coming
//   in until a second finished frame waits in the decoder register; rx.ready
//   then drops until the result register frees.
//   Reset (rst, synchronous) returns the decoder to waiting for STX, empties
//   both registers and restores gain 5 and limit 500. The digit store has
//   no reset; every slot is written before a frame can complete.
// ---------------------------------------------------------------------------
`default_nettype none

module joystick_frame_to_wheel_speeds_unit import jfws_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  jfws_byte_if.sink        rx,
  jfws_speed_if.source     wheel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg;
  axes_t axes;
  logic  take;

  // Configuration registers.
  jfws_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Framing and axis decode.
  jfws_frame_decoder u_frame_decoder (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_byte  (rx.rx_byte),
    .in_ready (rx.ready),
    .take     (take),
    .axes     (axes)
  );

  // Scaling, mixing and result register.
  jfws_mixer u_mixer (
    .clk   (clk),
    .rst   (rst),
    .axes  (axes),
    .cfg   (cfg),
    .take  (take),
    .wheel (wheel)
  );

`ifndef NO_ASSERTIONS
  // Bytes are refused only while a result is waiting on the output.
  assert property (@(posedge clk) disable iff (rst) !rx.ready |-> wheel.valid)
    else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire
